// File: rtl/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// Shared constants and codes of the dependency level scheduler.
// ----------------------------------------------------------------------------
package dls_pkg;

    // field widths
    localparam int MASK_W   = 16;
    localparam int JIDX_W   = 4;
    localparam int ID_W     = 4;
    localparam int MACH_W   = 4;
    localparam int LEVEL_W  = 5;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    // sizing
    localparam int MAX_JOBS_DEFAULT = 16;
    localparam int RESULT_CAP       = 16;
    localparam int COUNT_W          = 5;

    // configuration reset values and indexes
    localparam logic [CFG_W-1:0]     JOB_COUNT_RESET  = 5'd16;
    localparam logic [CFG_W-1:0]     PROC_COUNT_RESET = 5'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_COUNT   = 1'd1;

    // item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_SCHEDULED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALL_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEADLOCK  = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd31;

endpackage

// File: rtl/dls_dep_mem.sv
// ----------------------------------------------------------------------------
// dls_dep_mem
// Dependency mask store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dls_dep_mem #(
    parameter int DEPTH  = dls_pkg::MAX_JOBS_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [dls_pkg::MASK_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [dls_pkg::MASK_W-1:0] rdata
);
    import dls_pkg::*;

    logic [MASK_W-1:0] dep_store [DEPTH];
    logic [MASK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            dep_store[waddr] <= wdata;
        end
    end

    // entries never written read as anything
    always_ff @(posedge clk)
    begin
        rdata_reg <= dep_store[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dependency_level_scheduler.sv
// ----------------------------------------------------------------------------
// dependency_level_scheduler
// Level-by-level list scheduling of jobs with precedence on limited processors.
// ----------------------------------------------------------------------------
// load: no result; all-done step: one result next cycle, still ready
// other steps: scan one job per cycle through the mask store read port over the
// effective job count, ending early once the processor limit is met, then one result
// a cycle per scheduled job, or one deadlock result; busy until the last is formed
// results show in the cycle after they are formed; the receiver cannot stall them
// reset clears done marks, level counter and sequencer, and presets the two registers
module dependency_level_scheduler #(
    parameter int MAX_JOBS = dls_pkg::MAX_JOBS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [dls_pkg::JIDX_W-1:0]        job_index,
    input  logic [dls_pkg::MASK_W-1:0]        dep_mask,
    input  logic                              cfg_we,
    input  logic [dls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dls_pkg::CFG_W-1:0]         cfg_data,
    output logic                              result_valid,
    output logic [dls_pkg::STATUS_W-1:0]      status,
    output logic [dls_pkg::ID_W-1:0]          job_id,
    output logic [dls_pkg::MACH_W-1:0]        machine,
    output logic [dls_pkg::LEVEL_W-1:0]       level,
    output logic                              finished,
    output logic                              last
);
    import dls_pkg::*;

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int JC_W  = $clog2(MAX_JOBS + 1);
    localparam int SLOT_W = $clog2(RESULT_CAP);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CFG_W-1:0]    job_count_reg, proc_count_reg;
    logic [MAX_JOBS-1:0] done_reg, done_next;
    logic [MAX_JOBS-1:0] chosen_reg, chosen_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [JC_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]    eval_idx_reg, eval_idx_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [SLOT_W-1:0]   out_idx_reg, out_idx_next;
    logic                fin_reg, fin_next;

    logic                result_valid_reg, result_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     job_id_reg, job_id_next;
    logic [MACH_W-1:0]   machine_reg, machine_next;
    logic [LEVEL_W-1:0]  level_out_reg, level_out_next;
    logic                finished_reg, finished_next;
    logic                last_reg, last_next;

    logic [ID_W-1:0]     id_list_reg [RESULT_CAP];
    logic                id_we;

    logic [JC_W-1:0]     jc;
    logic [COUNT_W-1:0]  limit;
    logic [MAX_JOBS-1:0] act;
    logic [MAX_JOBS-1:0] done_act;
    logic [MASK_W-1:0]   met;
    logic                all_done;
    logic                accept;
    logic                load_we;
    logic [IDX_W-1:0]    load_addr;
    logic [MASK_W-1:0]   rd_mask;
    logic                issue;
    logic                ready;
    logic                end_scan;
    logic                emit_last;

    assign accept    = start && !busy;
    assign load_we   = accept && (mode == MODE_LOAD) && (int'(job_index) < MAX_JOBS);
    assign load_addr = IDX_W'(job_index);

    dls_dep_mem #(
        .DEPTH  (MAX_JOBS),
        .ADDR_W (IDX_W)
    ) u_dep_mem (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (dep_mask),
        .raddr (issue_idx_reg[IDX_W-1:0]),
        .rdata (rd_mask)
    );

    // effective job count and processor limit
    always_comb
    begin
        if (int'(job_count_reg) < MAX_JOBS)
        begin
            jc = JC_W'(job_count_reg);
        end
        else
        begin
            jc = JC_W'(MAX_JOBS);
        end
        if (proc_count_reg == '0)
        begin
            limit = COUNT_W'(1);
        end
        else if (int'(proc_count_reg) > RESULT_CAP)
        begin
            limit = COUNT_W'(RESULT_CAP);
        end
        else
        begin
            limit = proc_count_reg;
        end
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            act[i] = (i < int'(jc));
        end
    end

    assign done_act = done_reg & act;
    assign all_done = (done_act == act);

    // dependency bits beyond the job range are never met
    for (genvar k = 0; k < MASK_W; k++)
    begin : g_met
        if (k < MAX_JOBS)
        begin : g_in
            assign met[k] = done_act[k];
        end
        else
        begin : g_out
            assign met[k] = 1'b0;
        end
    end

    assign issue     = (issue_idx_reg < jc);
    assign ready     = !done_reg[eval_idx_reg] && ((rd_mask & ~met) == '0);
    assign end_scan  = (n_reg == limit) || (!eval_vld_reg && !issue);
    assign emit_last = ({1'b0, out_idx_reg} == n_reg - COUNT_W'(1));
    assign id_we     = (state_reg == S_SCAN) && eval_vld_reg && (n_reg < limit) && ready;

    always_comb
    begin
        state_next        = state_reg;
        done_next         = done_reg;
        chosen_next       = chosen_reg;
        level_next        = level_reg;
        issue_idx_next    = issue_idx_reg;
        eval_vld_next     = 1'b0;
        eval_idx_next     = eval_idx_reg;
        n_next            = n_reg;
        out_idx_next      = out_idx_reg;
        fin_next          = fin_reg;
        result_valid_next = 1'b0;
        status_next       = status_reg;
        job_id_next       = job_id_reg;
        machine_next      = machine_reg;
        level_out_next    = level_out_reg;
        finished_next     = finished_reg;
        last_next         = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode == MODE_STEP))
                begin
                    if (all_done)
                    begin
                        result_valid_next = 1'b1;
                        status_next       = STATUS_ALL_DONE;
                        job_id_next       = '0;
                        machine_next      = '0;
                        level_out_next    = level_reg;
                        finished_next     = 1'b1;
                        last_next         = 1'b1;
                    end
                    else
                    begin
                        if (level_reg != LEVEL_MAX)
                        begin
                            level_next = level_reg + LEVEL_W'(1);
                        end
                        issue_idx_next = '0;
                        n_next         = '0;
                        chosen_next    = '0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                eval_vld_next = issue;
                eval_idx_next = issue_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + JC_W'(1);
                end
                if (id_we)
                begin
                    chosen_next[eval_idx_reg] = 1'b1;
                    n_next = n_reg + COUNT_W'(1);
                end
                if (end_scan)
                begin
                    eval_vld_next = 1'b0;
                    if (n_reg == '0)
                    begin
                        result_valid_next = 1'b1;
                        status_next       = STATUS_DEADLOCK;
                        job_id_next       = '0;
                        machine_next      = '0;
                        level_out_next    = level_reg;
                        finished_next     = 1'b0;
                        last_next         = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        // chosen jobs count as done from the next level on
                        done_next    = done_reg | chosen_reg;
                        fin_next     = (((done_reg | chosen_reg) & act) == act);
                        out_idx_next = '0;
                        state_next   = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                result_valid_next = 1'b1;
                status_next       = STATUS_SCHEDULED;
                job_id_next       = id_list_reg[out_idx_reg];
                machine_next      = MACH_W'(out_idx_reg);
                level_out_next    = level_reg;
                finished_next     = fin_reg;
                last_next         = emit_last;
                out_idx_next      = out_idx_reg + SLOT_W'(1);
                if (emit_last)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            job_count_reg    <= JOB_COUNT_RESET;
            proc_count_reg   <= PROC_COUNT_RESET;
            done_reg         <= '0;
            chosen_reg       <= '0;
            level_reg        <= '0;
            issue_idx_reg    <= '0;
            eval_vld_reg     <= 1'b0;
            n_reg            <= '0;
            out_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            done_reg         <= done_next;
            chosen_reg       <= chosen_next;
            level_reg        <= level_next;
            issue_idx_reg    <= issue_idx_next;
            eval_vld_reg     <= eval_vld_next;
            n_reg            <= n_next;
            out_idx_reg      <= out_idx_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_JOB_COUNT)
                begin
                    job_count_reg <= cfg_data;
                end
                else if (cfg_index == REG_PROC_COUNT)
                begin
                    proc_count_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg  <= eval_idx_next;
        fin_reg       <= fin_next;
        status_reg    <= status_next;
        job_id_reg    <= job_id_next;
        machine_reg   <= machine_next;
        level_out_reg <= level_out_next;
        finished_reg  <= finished_next;
        last_reg      <= last_next;
        if (id_we)
        begin
            id_list_reg[n_reg[SLOT_W-1:0]] <= ID_W'(eval_idx_reg);
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign job_id       = job_id_reg;
    assign machine      = machine_reg;
    assign level        = level_out_reg;
    assign finished     = finished_reg;
    assign last         = last_reg;

    // scheduled count never passes the processor limit
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (n_reg <= limit))
        else $error("scheduled count above processor limit");

    // a job already done is never chosen again
    a_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((chosen_reg & done_reg) == '0))
        else $error("done job chosen again");

    // result phase only runs with at least one scheduled job
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (n_reg != '0))
        else $error("result phase with no scheduled job");

    // every result of a running level carries the current level number
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != STATUS_ALL_DONE))
        |-> ((level == level_reg) && (level != '0)))
        else $error("result level mismatch");

    // a step taken while jobs remain advances the level on start, unless it is at its maximum
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_STEP) && !all_done && (level_reg != LEVEL_MAX))
        |=> (level_reg == $past(level_reg) + LEVEL_W'(1)))
        else $error("level counter did not advance");

endmodule

// File: dv/tb_dependency_level_scheduler.sv
// ----------------------------------------------------------------------------
// tb_dependency_level_scheduler
// Self-checking bench for the level-by-level job scheduler: load and step
// transactions go in through the command port, a behavioral predictor tracks
// masks, done marks and the level count, and every result strobe is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_dependency_level_scheduler;
    import dls_pkg::*;

    localparam int TAIL_CYCLES = 48;
    localparam int CYCLE_LIMIT = 250000;
    localparam int N_PHASES    = 8;

    typedef struct packed {
        logic              mode;
        logic [JIDX_W-1:0] job_index;
        logic [MASK_W-1:0] dep_mask;
    } sched_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     job_id;
        logic [MACH_W-1:0]   machine;
        logic [LEVEL_W-1:0]  level;
        logic                finished;
        logic                last;
    } sched_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 mode = MODE_LOAD;
    logic [JIDX_W-1:0]    job_index = '0;
    logic [MASK_W-1:0]    dep_mask = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_JOB_COUNT;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 result_valid;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      job_id;
    logic [MACH_W-1:0]    machine;
    logic [LEVEL_W-1:0]   level;
    logic                 finished;
    logic                 last;

    dependency_level_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .job_index    (job_index),
        .dep_mask     (dep_mask),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .job_id       (job_id),
        .machine      (machine),
        .level        (level),
        .finished     (finished),
        .last         (last)
    );

    // scheduler state as the bench sees it
    logic [MASK_W-1:0]  dep_table [MASK_W];
    logic [MASK_W-1:0]  done_set = '0;
    logic [LEVEL_W-1:0] level_now = '0;
    logic [CFG_W-1:0]   jobs_reg = JOB_COUNT_RESET;
    logic [CFG_W-1:0]   procs_reg = PROC_COUNT_RESET;

    sched_cmd_t    job_cmds [$];
    sched_result_t expected_slots [$];
    sched_cmd_t    in_hand;
    int            idle_pct = 0;
    int            mismatches = 0;
    int            cycle_count = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // a step runs a level or reports all done; a load only updates the mask store
    function automatic void predict_schedule(sched_cmd_t cmd);
        int            jc;
        int            lim;
        int            n;
        logic [15:0]   act;
        logic [15:0]   chosen;
        logic          fin;
        sched_result_t r;
        if (cmd.mode == MODE_LOAD)
        begin
            dep_table[cmd.job_index] = cmd.dep_mask;
            return;
        end
        jc  = (jobs_reg > MAX_JOBS_DEFAULT) ? MAX_JOBS_DEFAULT : int'(jobs_reg);
        act = (jc == MAX_JOBS_DEFAULT) ? 16'hFFFF : 16'((32'd1 << jc) - 32'd1);
        r   = '0;
        if ((done_set & act) == act)
        begin
            r.status   = STATUS_ALL_DONE;
            r.level    = level_now;
            r.finished = 1'b1;
            r.last     = 1'b1;
            expected_slots.push_back(r);
            return;
        end
        if (level_now != LEVEL_MAX)
            level_now = level_now + 1'b1;
        lim = (procs_reg == 0) ? 1 : int'(procs_reg);
        if (lim > RESULT_CAP)
            lim = RESULT_CAP;
        chosen = '0;
        n = 0;
        // readiness looks only at marks from earlier levels
        for (int i = 0; i < jc && n < lim; i++)
        begin
            if (!done_set[i] && (dep_table[i] & ~(done_set & act)) == '0)
            begin
                chosen[i] = 1'b1;
                n++;
            end
        end
        r.level = level_now;
        if (n == 0)
        begin
            r.status = STATUS_DEADLOCK;
            r.last   = 1'b1;
            expected_slots.push_back(r);
            return;
        end
        done_set = done_set | chosen;
        fin = ((done_set & act) == act);
        n = 0;
        for (int i = 0; i < MAX_JOBS_DEFAULT; i++)
        begin
            if (chosen[i])
            begin
                r.status   = STATUS_SCHEDULED;
                r.job_id   = ID_W'(i);
                r.machine  = MACH_W'(n);
                r.finished = fin;
                r.last     = ((chosen >> (i + 1)) == '0);
                expected_slots.push_back(r);
                n++;
            end
        end
    endfunction

    // mostly acyclic masks on lower jobs, plus zero, all-ones, self and noise
    function automatic sched_cmd_t random_cmd(int span);
        sched_cmd_t cmd;
        int         j;
        int         pick;
        cmd.mode = ($urandom_range(99) < 40) ? MODE_STEP : MODE_LOAD;
        if (span == 0 || $urandom_range(9) == 0)
            j = $urandom_range(15);
        else
            j = $urandom_range(span - 1);
        cmd.job_index = JIDX_W'(j);
        pick = $urandom_range(99);
        if (pick < 55)
            cmd.dep_mask = MASK_W'($urandom() & ((32'd1 << j) - 32'd1));
        else if (pick < 70)
            cmd.dep_mask = '0;
        else if (pick < 85)
            cmd.dep_mask = MASK_W'($urandom());
        else if (pick < 93)
            cmd.dep_mask = '1;
        else
            cmd.dep_mask = MASK_W'(32'd1 << j);
        return cmd;
    endfunction

    function automatic sched_cmd_t make_cmd(logic m, int idx, logic [MASK_W-1:0] msk);
        sched_cmd_t cmd;
        cmd.mode      = m;
        cmd.job_index = JIDX_W'(idx);
        cmd.dep_mask  = msk;
        return cmd;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        if (idx == REG_JOB_COUNT)
            jobs_reg = CFG_W'(value);
        else
            procs_reg = CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for the queue to drain, all results in, and the block quiet
    task automatic settle();
        do
            @(negedge clk);
        while (job_cmds.size() != 0 || start || expected_slots.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic hold;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            hold = start;
            if (start && !busy)
            begin
                predict_schedule(in_hand);
                hold = 1'b0;
            end
            if (!hold && job_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_hand = job_cmds.pop_front();
                mode      <= in_hand.mode;
                job_index <= in_hand.job_index;
                dep_mask  <= in_hand.dep_mask;
                hold = 1'b1;
            end
            start <= hold;
        end
    end

    always @(posedge clk)
    begin : monitor
        sched_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_slots.size() == 0)
            begin
                $error("result transaction with none expected: status %0d job %0d",
                       status, job_id);
                mismatches++;
            end
            else
            begin
                want = expected_slots.pop_front();
                check_field("status", want.status, status);
                check_field("job_id", want.job_id, job_id);
                check_field("machine", want.machine, machine);
                check_field("level", want.level, level);
                check_field("finished", want.finished, finished);
                check_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : sequencer
        int jc_set;
        int pc_set;
        int n_cmds;
        int span;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every mask written first, all blocked on themselves
        job_cmds.push_back(make_cmd(MODE_LOAD, 0, '1));
        for (int j = 1; j < MAX_JOBS_DEFAULT; j++)
            job_cmds.push_back(make_cmd(MODE_LOAD, j, MASK_W'(32'd1 << j)));
        job_cmds.push_back(make_cmd(MODE_STEP, 0, '0));
        // release a two-job chain; second one waits for the next level
        job_cmds.push_back(make_cmd(MODE_LOAD, 0, '0));
        job_cmds.push_back(make_cmd(MODE_LOAD, 1, 16'h0001));
        job_cmds.push_back(make_cmd(MODE_STEP, 15, '1));
        job_cmds.push_back(make_cmd(MODE_STEP, 0, '0));
        job_cmds.push_back(make_cmd(MODE_STEP, 0, '0));

        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            case (p)
                0: begin jc_set = 0;  pc_set = 0;  idle_pct = 0;  n_cmds = 12; end
                1: begin jc_set = 4;  pc_set = 1;  idle_pct = 72; n_cmds = 45; end
                2: begin jc_set = 1;  pc_set = 16; idle_pct = 0;  n_cmds = 15; end
                3: begin jc_set = 8;  pc_set = 3;  idle_pct = 8;  n_cmds = 50; end
                4: begin jc_set = 12; pc_set = 2;  idle_pct = 72; n_cmds = 50; end
                5: begin jc_set = 31; pc_set = 31; idle_pct = 0;  n_cmds = 50; end
                6: begin jc_set = 20; pc_set = 17; idle_pct = 8;  n_cmds = 40; end
                default: begin jc_set = 16; pc_set = 16; idle_pct = 72; n_cmds = 40; end
            endcase
            write_reg(REG_JOB_COUNT, jc_set);
            write_reg(REG_PROC_COUNT, pc_set);
            span = (jc_set > MAX_JOBS_DEFAULT) ? MAX_JOBS_DEFAULT : jc_set;
            repeat (n_cmds) job_cmds.push_back(random_cmd(span));
        end
        settle();

        if (mismatches == 0 && expected_slots.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
